// File: design/ntmt_pkg.sv
// ----------------------------------------------------------------------------
// ntmt_pkg
// Shared types and constants of the non-overlapping template match test.
// ----------------------------------------------------------------------------
package ntmt_pkg;

   localparam int TEMPLATE_W  = 9;
   localparam int BLOCK_W     = 21;
   localparam int TOTAL_W     = 8;
   localparam int MEAN_W      = 36;
   localparam int IVAR_W      = 48;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int COUNT_W     = 20;
   localparam int CHI_W       = 48;

   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam int CHUNK_W     = 24;
   localparam int MUL_A_W     = 72;
   localparam int MUL_B_W     = 48;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [CHI_W-1:0]   CHI_MAX   = {CHI_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMPLATE_BITS    = 3'd0,
      CSR_BLOCK_BYTES      = 3'd1,
      CSR_BLOCK_TOTAL      = 3'd2,
      CSR_EXPECTED_MEAN    = 3'd3,
      CSR_INVERSE_VARIANCE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TEMPLATE_W-1:0] template_bits;
      logic [BLOCK_W-1:0]    block_bytes;
      logic [TOTAL_W-1:0]    block_total;
   } front_cfg_type;

   typedef struct packed {
      logic [MEAN_W-1:0] expected_mean;
      logic [IVAR_W-1:0] inverse_variance;
   } back_cfg_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] block_number;
      logic [COUNT_W-1:0] match_count;
      logic               last_block;
   } block_rec_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SQUARE,
      BK_SCALE,
      BK_EMIT
   } back_state_type;

endpackage

// File: design/ntmt_front.sv
// ----------------------------------------------------------------------------
// ntmt_front
// Takes stream words, scans their bits for the template and closes blocks.
// ----------------------------------------------------------------------------
module ntmt_front
   import ntmt_pkg::*;
#(
   parameter int TEMPLATE_LEN = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  front_cfg_type           cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  queue_status_type        q_status,
   output logic                    q_push,
   output block_rec_type           q_rec
);

   localparam int FILL_W = $clog2(TEMPLATE_LEN + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TEMPLATE_LEN);

   logic [TEMPLATE_LEN-1:0] window_ff, window_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [COUNT_W-1:0]      matches_ff, matches_in;
   logic [BLOCK_W-1:0]      bytes_ff, bytes_in;
   logic [TOTAL_W-1:0]      block_ff, block_in;

   logic [TEMPLATE_LEN+TEMPLATE_W-1:0] tmpl_ext;
   logic [TEMPLATE_LEN-1:0]            tmpl;
   logic [TEMPLATE_LEN-1:0]            scan_window;
   logic [FILL_W-1:0]                  scan_fill;
   logic [COUNT_W-1:0]                 scan_matches;
   logic [BLOCK_W-1:0]                 bytes_next;
   logic                               block_end;
   logic                               last;
   logic                               accept;

   assign tmpl_ext = {{TEMPLATE_LEN{1'b0}}, cfg.template_bits};
   assign tmpl     = tmpl_ext[TEMPLATE_LEN-1:0];

   always_comb begin
      logic [TEMPLATE_LEN-1:0] w;
      logic [FILL_W-1:0]       f;
      logic [COUNT_W-1:0]      m;
      w = window_ff;
      f = fill_ff;
      m = matches_ff;
      for (int k = 7; k >= 0; k--) begin
         w = {w[TEMPLATE_LEN-2:0], req_data_byte[k]};
         if (f < FILL_FULL) begin
            f = f + FILL_W'(1);
         end
         if (f >= FILL_FULL) begin
            if (w == tmpl) begin
               if (m != COUNT_MAX) begin
                  m = m + COUNT_W'(1);
               end
               f = '0;
               w = '0;
            end else begin
               f = FILL_FULL;
            end
         end
      end
      scan_window  = w;
      scan_fill    = f;
      scan_matches = m;
   end

   assign bytes_next = bytes_ff + BLOCK_W'(1);
   assign block_end  = bytes_next >= cfg.block_bytes;
   assign last       = ({1'b0, block_ff} + 9'd1) >= {1'b0, cfg.block_total};

   // stall only a word that closes a block while the queue is full
   assign req_ready = !(block_end && q_status.full);
   assign accept    = req_valid && req_ready;

   assign q_push             = accept && block_end;
   assign q_rec.block_number = block_ff;
   assign q_rec.match_count  = scan_matches;
   assign q_rec.last_block   = last;

   always_comb begin
      window_in  = window_ff;
      fill_in    = fill_ff;
      matches_in = matches_ff;
      bytes_in   = bytes_ff;
      block_in   = block_ff;
      if (accept) begin
         if (block_end) begin
            window_in  = '0;
            fill_in    = '0;
            matches_in = '0;
            bytes_in   = '0;
            block_in   = last ? '0 : block_ff + TOTAL_W'(1);
         end else begin
            window_in  = scan_window;
            fill_in    = scan_fill;
            matches_in = scan_matches;
            bytes_in   = bytes_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         fill_ff    <= '0;
         matches_ff <= '0;
         bytes_ff   <= '0;
         block_ff   <= '0;
      end else begin
         window_ff  <= window_in;
         fill_ff    <= fill_in;
         matches_ff <= matches_in;
         bytes_ff   <= bytes_in;
         block_ff   <= block_in;
      end
   end

endmodule

// File: design/ntmt_queue.sv
// ----------------------------------------------------------------------------
// ntmt_queue
// Short queue of finished block records between front and back.
// ----------------------------------------------------------------------------
module ntmt_queue
   import ntmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  block_rec_type    push_rec,
   input  logic             pop,
   output block_rec_type    pop_rec,
   output queue_status_type status
);

   block_rec_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign pop_rec      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/ntmt_back.sv
// ----------------------------------------------------------------------------
// ntmt_back
// Computes the chi-square term of each block, accumulates and drives results.
// ----------------------------------------------------------------------------
module ntmt_back
   import ntmt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  back_cfg_type       cfg,
   input  queue_status_type   q_status,
   input  block_rec_type      q_rec,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [TOTAL_W-1:0] rsp_block_number,
   output logic [COUNT_W-1:0] rsp_match_count,
   output logic [CHI_W-1:0]   rsp_chi_square_sum,
   output logic               rsp_last_block
);

   back_state_type       state_ff, state_in;
   block_rec_type        rec_ff;
   logic [MUL_A_W-1:0]   a_ff;
   logic [MUL_B_W-1:0]   b_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [2*CHUNK_W-1:0] pp_ff;
   logic [1:0]           ia_ff;
   logic                 jb_ff;
   logic                 phase_ff;
   logic [CHI_W-1:0]     acc_ff;
   logic                 rsp_valid_ff;
   logic [TOTAL_W-1:0]   out_block_ff;
   logic [COUNT_W-1:0]   out_count_ff;
   logic [CHI_W-1:0]     out_chi_ff;
   logic                 out_last_ff;

   logic [MEAN_W-1:0]    count_q;
   logic [MEAN_W-1:0]    diff;
   logic [CHUNK_W-1:0]   a_chunk;
   logic [CHUNK_W-1:0]   b_chunk;
   logic [2:0]           pos;
   logic [PROD_W-1:0]    pp_shifted;
   logic [PROD_W-1:0]    prod_sum;
   logic                 mul_busy;
   logic                 mul_last;
   logic [CHI_W-1:0]     term;
   logic [CHI_W:0]       acc_wide;
   logic [CHI_W-1:0]     acc_sat;
   logic                 out_free;
   logic                 out_load;

   assign count_q = {q_rec.match_count, 16'h0000};
   assign diff    = (count_q >= cfg.expected_mean) ? count_q - cfg.expected_mean
                                                   : cfg.expected_mean - count_q;

   always_comb begin
      unique case (ia_ff)
         2'd0:    a_chunk = a_ff[CHUNK_W-1:0];
         2'd1:    a_chunk = a_ff[2*CHUNK_W-1:CHUNK_W];
         default: a_chunk = a_ff[3*CHUNK_W-1:2*CHUNK_W];
      endcase
      b_chunk = jb_ff ? b_ff[2*CHUNK_W-1:CHUNK_W] : b_ff[CHUNK_W-1:0];
   end

   assign pos = {1'b0, ia_ff} + {2'b00, jb_ff};

   always_comb begin
      unique case (pos)
         3'd0:    pp_shifted = PROD_W'(pp_ff);
         3'd1:    pp_shifted = PROD_W'(pp_ff) << CHUNK_W;
         3'd2:    pp_shifted = PROD_W'(pp_ff) << (2*CHUNK_W);
         3'd3:    pp_shifted = PROD_W'(pp_ff) << (3*CHUNK_W);
         default: pp_shifted = PROD_W'(pp_ff) << (4*CHUNK_W);
      endcase
   end

   assign prod_sum = prod_ff + pp_shifted;
   assign mul_busy = (state_ff == BK_SQUARE) || (state_ff == BK_SCALE);
   assign mul_last = phase_ff && (ia_ff == 2'd2) && jb_ff;

   assign term     = (prod_ff[PROD_W-1:96] != '0) ? CHI_MAX : prod_ff[95:48];
   assign acc_wide = {1'b0, acc_ff} + {1'b0, term};
   assign acc_sat  = acc_wide[CHI_W] ? CHI_MAX : acc_wide[CHI_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (!q_status.empty) state_in = BK_SQUARE;
         BK_SQUARE: if (mul_last) state_in = BK_SCALE;
         BK_SCALE:  if (mul_last) state_in = BK_EMIT;
         BK_EMIT:   if (out_free) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         BK_IDLE:   q_pop = !q_status.empty;
         BK_SQUARE: ;
         BK_SCALE:  ;
         BK_EMIT:   out_load = out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff  <= q_rec;
         a_ff    <= MUL_A_W'(diff);
         b_ff    <= MUL_B_W'(diff);
         prod_ff <= '0;
      end else if (mul_busy) begin
         if (!phase_ff) begin
            pp_ff <= a_chunk * b_chunk;
         end else if (mul_last && state_ff == BK_SQUARE) begin
            a_ff    <= prod_sum[MUL_A_W-1:0];
            b_ff    <= cfg.inverse_variance;
            prod_ff <= '0;
         end else begin
            prod_ff <= prod_sum;
         end
      end
      if (out_load) begin
         out_block_ff <= rec_ff.block_number;
         out_count_ff <= rec_ff.match_count;
         out_chi_ff   <= acc_sat;
         out_last_ff  <= rec_ff.last_block;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ia_ff        <= '0;
         jb_ff        <= 1'b0;
         phase_ff     <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop) begin
            ia_ff    <= '0;
            jb_ff    <= 1'b0;
            phase_ff <= 1'b0;
         end else if (mul_busy) begin
            phase_ff <= !phase_ff;
            if (phase_ff) begin
               if (ia_ff == 2'd2) begin
                  ia_ff <= '0;
                  jb_ff <= !jb_ff;
               end else begin
                  ia_ff <= ia_ff + 2'd1;
               end
            end
         end
         if (out_load) begin
            acc_ff       <= rec_ff.last_block ? '0 : acc_sat;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_block_number   = out_block_ff;
   assign rsp_match_count    = out_count_ff;
   assign rsp_chi_square_sum = out_chi_ff;
   assign rsp_last_block     = out_last_ff;

`ifndef NO_ASSERTIONS
   a_rise_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == BK_EMIT)
      else $error("result raised outside emit");

   a_chunk_range: assert property (@(posedge clock) disable iff (reset)
      ia_ff != 2'd3)
      else $error("multiplier chunk index out of range");

   a_phase_toggle: assert property (@(posedge clock) disable iff (reset)
      mul_busy && !phase_ff |=> phase_ff)
      else $error("multiply step skipped its add phase");

   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      out_load && rec_ff.last_block |=> acc_ff == '0)
      else $error("chi sum not cleared after last block");
`endif

endmodule

// File: design/nonoverlapping_template_match_test_top.sv
// ----------------------------------------------------------------------------
// nonoverlapping_template_match_test_top
// Non-overlapping template match health test with chi-square accumulation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_data_byte
//  rsp     | out       | rsp_valid / rsp_ready  | block number, count, chi sum, last
//  csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
//  Unless stalled, one word is taken per cycle; all eight bits are scanned at once.
//  Each block end is worked through in the chi unit (one 24x24 multiplier,
//  six partial products per multiply, two multiplies).
//  A four-record queue lets blocks close while the chi unit is busy; the
//  front stalls only a block-closing word when that queue is full.
//  Synchronous reset restores register defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
module nonoverlapping_template_match_test_top
   import ntmt_pkg::*;
#(
   parameter int TEMPLATE_LEN = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TOTAL_W-1:0]     rsp_block_number,
   output logic [COUNT_W-1:0]     rsp_match_count,
   output logic [CHI_W-1:0]       rsp_chi_square_sum,
   output logic                   rsp_last_block,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   front_cfg_type    front_cfg_ff;
   back_cfg_type     back_cfg_ff;
   queue_status_type q_status;
   block_rec_type    push_rec;
   block_rec_type    pop_rec;
   logic             q_push;
   logic             q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff.template_bits <= TEMPLATE_W'(273);
         front_cfg_ff.block_bytes   <= BLOCK_W'(1024);
         front_cfg_ff.block_total   <= TOTAL_W'(10);
         back_cfg_ff.expected_mean  <= '0;
         back_cfg_ff.inverse_variance <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TEMPLATE_BITS:
               front_cfg_ff.template_bits <= csr_write_data[TEMPLATE_W-1:0];
            CSR_BLOCK_BYTES:
               front_cfg_ff.block_bytes <= csr_write_data[BLOCK_W-1:0];
            CSR_BLOCK_TOTAL:
               front_cfg_ff.block_total <= csr_write_data[TOTAL_W-1:0];
            CSR_EXPECTED_MEAN:
               back_cfg_ff.expected_mean <= csr_write_data[MEAN_W-1:0];
            CSR_INVERSE_VARIANCE:
               back_cfg_ff.inverse_variance <= csr_write_data[IVAR_W-1:0];
            default: ;
         endcase
      end
   end

   ntmt_front #(
      .TEMPLATE_LEN(TEMPLATE_LEN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (front_cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_rec         (push_rec)
   );

   ntmt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .pop      (q_pop),
      .pop_rec  (pop_rec),
      .status   (q_status)
   );

   ntmt_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (back_cfg_ff),
      .q_status           (q_status),
      .q_rec              (pop_rec),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_block_number   (rsp_block_number),
      .rsp_match_count    (rsp_match_count),
      .rsp_chi_square_sum (rsp_chi_square_sum),
      .rsp_last_block     (rsp_last_block)
   );

endmodule

// File: sim/ntmt_block_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ntmt_block_checker
// Watches the word, result and register ports of the template match test,
// keeps its own copy of the settings and the scan state, works out the block
// result that each accepted word closes, and compares every delivered result
// with the oldest one still due. Hands back the number of results still due
// and the number of bad or unexpected results.
// ----------------------------------------------------------------------------
module ntmt_block_checker
   import ntmt_pkg::*;
#(
   parameter int TLEN = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [TOTAL_W-1:0]     rsp_block_number,
   input  logic [COUNT_W-1:0]     rsp_match_count,
   input  logic [CHI_W-1:0]       rsp_chi_square_sum,
   input  logic                   rsp_last_block,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int unsigned            pending_blocks,
   output int unsigned            mismatches
);

   localparam logic [TEMPLATE_W-1:0] TEMPLATE_DEFAULT = 9'd273;
   localparam logic [BLOCK_W-1:0]    SIZE_DEFAULT     = 21'd1024;
   localparam logic [TOTAL_W-1:0]    TOTAL_DEFAULT    = 8'd10;
   localparam int                    REPORT_MAX       = 10;

   typedef struct {
      logic [TOTAL_W-1:0] block_number;
      logic [COUNT_W-1:0] match_count;
      logic [CHI_W-1:0]   chi_sum;
      logic               last_block;
   } block_result_type;

   logic [TEMPLATE_W-1:0] pattern_q;
   logic [BLOCK_W-1:0]    size_q;
   logic [TOTAL_W-1:0]    total_q;
   logic [MEAN_W-1:0]     mean_q;
   logic [IVAR_W-1:0]     ivar_q;

   logic [TLEN-1:0]    window;
   int unsigned        fill;
   logic [COUNT_W-1:0] hits;
   logic [BLOCK_W-1:0] words_in_block;
   logic [TOTAL_W-1:0] block_idx;
   logic [CHI_W-1:0]   chi_running;

   block_result_type results_due[$];
   int unsigned      bad_results;

   function automatic logic [CHI_W-1:0] chi_term_of(input logic [COUNT_W-1:0] count);
      logic [MEAN_W-1:0]            scaled;
      logic [MEAN_W-1:0]            delta;
      logic [2*MEAN_W-1:0]          delta_sq;
      logic [2*MEAN_W+IVAR_W-1:0]   prod;
      scaled   = {count, 16'd0};
      delta    = (scaled >= mean_q) ? scaled - mean_q : mean_q - scaled;
      delta_sq = delta * delta;
      prod     = delta_sq * ivar_q;
      if (|prod[2*MEAN_W+IVAR_W-1:96]) begin
         return CHI_MAX;
      end
      return prod[95:48];
   endfunction

   always @(posedge clock) begin
      logic [CHI_W:0]   chi_wide;
      logic             is_last;
      block_result_type want;
      if (reset) begin
         pattern_q      = TEMPLATE_DEFAULT;
         size_q         = SIZE_DEFAULT;
         total_q        = TOTAL_DEFAULT;
         mean_q         = '0;
         ivar_q         = '0;
         window         = '0;
         fill           = 0;
         hits           = '0;
         words_in_block = '0;
         block_idx      = '0;
         chi_running    = '0;
         bad_results    = 0;
         results_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TEMPLATE_BITS:    pattern_q = csr_write_data[TEMPLATE_W-1:0];
               CSR_BLOCK_BYTES:      size_q    = csr_write_data[BLOCK_W-1:0];
               CSR_BLOCK_TOTAL:      total_q   = csr_write_data[TOTAL_W-1:0];
               CSR_EXPECTED_MEAN:    mean_q    = csr_write_data[MEAN_W-1:0];
               CSR_INVERSE_VARIANCE: ivar_q    = csr_write_data[IVAR_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            for (int k = 7; k >= 0; k--) begin
               window = {window[TLEN-2:0], req_data_byte[k]};
               if (fill < TLEN) begin
                  fill++;
               end
               if (fill >= TLEN) begin
                  if (window == TLEN'(pattern_q)) begin
                     if (hits != COUNT_MAX) begin
                        hits++;
                     end
                     fill   = 0;
                     window = '0;
                  end else begin
                     fill = TLEN;
                  end
               end
            end
            words_in_block = words_in_block + 1'b1;
            if (words_in_block >= size_q) begin
               chi_wide    = {1'b0, chi_running} + chi_term_of(hits);
               chi_running = chi_wide[CHI_W] ? CHI_MAX : chi_wide[CHI_W-1:0];
               is_last     = ({1'b0, block_idx} + 9'd1) >= {1'b0, total_q};
               want.block_number = block_idx;
               want.match_count  = hits;
               want.chi_sum      = chi_running;
               want.last_block   = is_last;
               results_due.push_back(want);
               window         = '0;
               fill           = 0;
               hits           = '0;
               words_in_block = '0;
               if (is_last) begin
                  block_idx   = '0;
                  chi_running = '0;
               end else begin
                  block_idx = block_idx + 1'b1;
               end
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               bad_results++;
               if (bad_results <= REPORT_MAX) begin
                  $display("unexpected block result: blk %0d cnt %0d chi %h last %0b",
                           rsp_block_number, rsp_match_count, rsp_chi_square_sum,
                           rsp_last_block);
               end
            end else begin
               want = results_due.pop_front();
               if (rsp_block_number !== want.block_number ||
                   rsp_match_count !== want.match_count ||
                   rsp_chi_square_sum !== want.chi_sum ||
                   rsp_last_block !== want.last_block) begin
                  bad_results++;
                  if (bad_results <= REPORT_MAX) begin
                     $display("block result mismatch: expected blk %0d cnt %0d chi %h last %0b",
                              want.block_number, want.match_count, want.chi_sum,
                              want.last_block);
                     $display("                       actual   blk %0d cnt %0d chi %h last %0b",
                              rsp_block_number, rsp_match_count, rsp_chi_square_sum,
                              rsp_last_block);
                  end
               end
            end
         end
      end
      pending_blocks <= results_due.size();
      mismatches     <= bad_results;
   end

endmodule

// File: sim/tb_nonoverlapping_template_match_test_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nonoverlapping_template_match_test_top
// Drives the template match test with a short directed sequence (reset
// settings, block size cut mid-block, zero and maximum settings, template
// change mid-block) and then phases of random settings fed by a bit stream
// rich in whole, broken and partial templates. Both sides pause at random,
// and one phase holds the result side off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_nonoverlapping_template_match_test_top;
   import ntmt_pkg::*;

   localparam int TLEN          = 9;
   localparam int GAP_MAX       = 12;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES  = 60;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASES        = 16;
   localparam int PHASE_WORDS   = 118;
   localparam int PRESSURE_PHASE = 2;

   localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};
   localparam logic [IVAR_W-1:0] IVAR_MAX = {IVAR_W{1'b1}};
   localparam logic [BLOCK_W-1:0] SIZE_MAX = {BLOCK_W{1'b1}};

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TOTAL_W-1:0]     rsp_block_number;
   logic [COUNT_W-1:0]     rsp_match_count;
   logic [CHI_W-1:0]       rsp_chi_square_sum;
   logic                   rsp_last_block;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   int unsigned pending_blocks;
   int unsigned mismatches;
   int unsigned cycle_count = 0;

   bit                    gaps_on = 1'b0;
   bit                    hold_rsp = 1'b0;
   logic [TEMPLATE_W-1:0] pattern_now = 9'd273;
   bit                    stream_bits[$];

   nonoverlapping_template_match_test_top #(
      .TEMPLATE_LEN(TLEN)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_block_number   (rsp_block_number),
      .rsp_match_count    (rsp_match_count),
      .rsp_chi_square_sum (rsp_chi_square_sum),
      .rsp_last_block     (rsp_last_block),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   ntmt_block_checker #(
      .TLEN(TLEN)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_block_number   (rsp_block_number),
      .rsp_match_count    (rsp_match_count),
      .rsp_chi_square_sum (rsp_chi_square_sum),
      .rsp_last_block     (rsp_last_block),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .pending_blocks     (pending_blocks),
      .mismatches         (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stall per result, one long hold on request
   initial begin
      int stall;
      forever begin
         stall = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall    = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   task automatic send_word(input logic [7:0] word);
      int gap;
      gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid, wait for every block result, then let the pipe drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_blocks != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it
   task automatic csr_put(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic load_all(input logic [TEMPLATE_W-1:0] tmpl, input logic [BLOCK_W-1:0] size,
                           input logic [TOTAL_W-1:0] total, input logic [MEAN_W-1:0] mean,
                           input logic [IVAR_W-1:0] ivar);
      pattern_now = tmpl;
      csr_put(CSR_TEMPLATE_BITS, CSR_DATA_W'(tmpl));
      csr_put(CSR_BLOCK_BYTES, CSR_DATA_W'(size));
      csr_put(CSR_BLOCK_TOTAL, CSR_DATA_W'(total));
      csr_put(CSR_EXPECTED_MEAN, CSR_DATA_W'(mean));
      csr_put(CSR_INVERSE_VARIANCE, CSR_DATA_W'(ivar));
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int                    r;
      int                    n;
      int                    flip;
      logic [7:0]            word;
      logic [TEMPLATE_W-1:0] tmpl;
      logic [BLOCK_W-1:0]    size;
      logic [TOTAL_W-1:0]    total;
      logic [MEAN_W-1:0]     mean;
      logic [IVAR_W-1:0]     ivar;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: template 100010001, long blocks
      send_word(8'h88);
      send_word(8'h80);
      send_word(8'h00);
      send_word(8'hFF);
      settle();
      // cut the block size below the bytes already taken
      csr_put(CSR_BLOCK_BYTES, 48'd2);
      csr_write_enable <= 1'b0;
      send_word(8'h00);
      settle();

      // zero block size, zero total, saturating chi
      load_all(9'h1FF, 21'd0, 8'd0, MEAN_MAX, IVAR_MAX);
      send_word(8'hFF);
      send_word(8'h00);
      settle();

      load_all(9'h000, 21'd3, 8'd255, 36'd0, 48'h0001_0000_0000);
      send_word(8'h00);
      send_word(8'h00);
      send_word(8'h00);
      send_word(8'h00);
      send_word(8'h00);
      settle();
      // template change inside a block
      pattern_now = 9'h155;
      csr_put(CSR_TEMPLATE_BITS, 48'h155);
      csr_write_enable <= 1'b0;
      send_word(8'hAA);
      settle();
      csr_put(CSR_BLOCK_BYTES, CSR_DATA_W'(SIZE_MAX));
      csr_write_enable <= 1'b0;
      send_word(8'h55);
      send_word(8'h0F);
      settle();
      csr_put(CSR_BLOCK_BYTES, 48'd1);
      csr_write_enable <= 1'b0;
      send_word(8'hF0);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         r = $urandom_range(0, 9);
         tmpl = (r == 0) ? 9'h000 : (r == 1) ? 9'h1FF : (r == 2) ? 9'd273
              : TEMPLATE_W'($urandom());
         r = $urandom_range(0, 9);
         size = (r == 0) ? 21'd0 : (r < 3) ? BLOCK_W'($urandom_range(40, 160))
              : BLOCK_W'($urandom_range(1, 24));
         r = $urandom_range(0, 9);
         total = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'd1
               : TOTAL_W'($urandom_range(2, 12));
         r = $urandom_range(0, 5);
         if (r == 0) begin
            mean = '0;
            ivar = '0;
         end else if (r == 1) begin
            mean = MEAN_W'({$urandom(), $urandom()});
            ivar = IVAR_W'({$urandom(), $urandom()});
         end else begin
            mean = {20'($urandom_range(0, 4)), 16'($urandom())};
            ivar = {14'd0, 2'($urandom()), 32'($urandom())};
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == PRESSURE_PHASE) begin
            size     = 21'd1;
            gaps_on  = 1'b0;
            hold_rsp = 1'b1;
         end
         load_all(tmpl, size, total, mean, ivar);

         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (i == PHASE_WORDS / 2 && phase[0]) begin
               settle();
               pattern_now = TEMPLATE_W'($urandom());
               csr_put(CSR_TEMPLATE_BITS, CSR_DATA_W'(pattern_now));
               csr_write_enable <= 1'b0;
            end
            while (stream_bits.size() < 8) begin
               r = $urandom_range(0, 9);
               if (r < 7) begin
                  n    = (r == 6) ? $urandom_range(1, TLEN - 1) : TLEN;
                  flip = (r >= 4 && r <= 5) ? $urandom_range(0, TLEN - 1) : -1;
                  for (int k = TLEN - 1; k >= TLEN - n; k--) begin
                     stream_bits.push_back(pattern_now[k] ^ (k == flip));
                  end
               end else begin
                  repeat (8) stream_bits.push_back($urandom_range(0, 1));
               end
            end
            for (int k = 7; k >= 0; k--) begin
               word[k] = stream_bits.pop_front();
            end
            send_word(word);
         end
         settle();
      end

      @(posedge clock);
      while (pending_blocks != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_blocks == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
